// ===== rtl/tes_pkg.sv =====
package tes_pkg;

  localparam int TAG_BITS  = 32;
  localparam int WAIT_BITS = 40;
  localparam int CNT_BITS  = 32;

  localparam logic [WAIT_BITS-1:0] WAIT_RESET = 40'd1000000;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;   // open a slot for the new event, shift larger entries up
    logic shift;    // front entry leaves, every entry moves one place down
  } cell_ctl_t;

endpackage

// ===== rtl/time_window_event_sorter_top.sv =====
// Time-window event sorter. Each event is inserted, stably by time, into a row of
// STORE_DEPTH+1 cells; the block then drains, oldest first, every event whose time
// lies at least max_wait ticks behind the newest stored time, one result per cycle
// through a registered output while the output is not stalled. If nothing is due
// and the row holds more than STORE_DEPTH events, the oldest one leaves with forced_out
// set. No new event is taken until the drain of the previous one is over, and
// every result leaves by the front cell's drain port. The final result of each item has
// last_of_run set. max_wait may only be written while no item is in progress.
module time_window_event_sorter_top #(
  parameter int STORE_DEPTH = 32,
  parameter int TIME_BITS   = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tes_pkg::WAIT_BITS-1:0]    max_wait,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [TIME_BITS-1:0]             event_time,
  input  logic [tes_pkg::TAG_BITS-1:0]     event_tag,
  input  logic                             event_dropped,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [TIME_BITS-1:0]             release_time,
  output logic [tes_pkg::TAG_BITS-1:0]     out_tag,
  output logic                             out_dropped,
  output logic                             forced_out,
  output logic [tes_pkg::CNT_BITS-1:0]     kept_total,
  output logic                             last_of_run
);

  localparam int NC = STORE_DEPTH + 1;
  localparam int OW = $clog2(STORE_DEPTH + 2);
  localparam int RW = $clog2(STORE_DEPTH + 1);
  localparam int CW = (TIME_BITS > tes_pkg::WAIT_BITS) ? TIME_BITS : tes_pkg::WAIT_BITS;

  tes_pkg::state_t state, state_next;
  logic [OW-1:0]                  occ, occ_next;
  logic [RW-1:0]                  rel, rel_next;
  logic [TIME_BITS-1:0]           newest, newest_next;
  logic [tes_pkg::WAIT_BITS-1:0]  wait_reg;
  logic [tes_pkg::CNT_BITS-1:0]   kept, kept_next;
  tes_pkg::cell_ctl_t             ctl;

  logic [TIME_BITS-1:0]         c_time [NC];
  logic [tes_pkg::TAG_BITS-1:0] c_tag  [NC];
  logic                         c_drp  [NC];
  logic                         c_gt   [NC];
  logic                         c_le   [NC];

  genvar gi;
  generate
    for (gi = 0; gi < NC; gi++) begin : g_cell
      logic                         p_gt, p_le, p_drp, n_drp;
      logic [TIME_BITS-1:0]         p_time, n_time;
      logic [tes_pkg::TAG_BITS-1:0] p_tag, n_tag;

      if (gi == 0) begin : g_head
        assign p_gt   = 1'b0;
        assign p_le   = 1'b1;
        assign p_time = event_time;
        assign p_tag  = event_tag;
        assign p_drp  = event_dropped;
      end else begin : g_body
        assign p_gt   = c_gt[gi-1];
        assign p_le   = c_le[gi-1];
        assign p_time = c_time[gi-1];
        assign p_tag  = c_tag[gi-1];
        assign p_drp  = c_drp[gi-1];
      end

      if (gi == NC - 1) begin : g_tail
        assign n_time = c_time[gi];
        assign n_tag  = c_tag[gi];
        assign n_drp  = c_drp[gi];
      end else begin : g_inner
        assign n_time = c_time[gi+1];
        assign n_tag  = c_tag[gi+1];
        assign n_drp  = c_drp[gi+1];
      end

      tes_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .occupied     (occ > OW'(gi)),
        .new_time     (event_time),
        .new_tag      (event_tag),
        .new_dropped  (event_dropped),
        .prev_gt      (p_gt),
        .prev_le      (p_le),
        .prev_time    (p_time),
        .prev_tag     (p_tag),
        .prev_dropped (p_drp),
        .next_time    (n_time),
        .next_tag     (n_tag),
        .next_dropped (n_drp),
        .gt           (c_gt[gi]),
        .le           (c_le[gi]),
        .cur_time     (c_time[gi]),
        .cur_tag      (c_tag[gi]),
        .cur_dropped  (c_drp[gi])
      );
    end
  endgenerate

  // release tests on the two front cells; stored times never exceed newest
  logic [TIME_BITS-1:0] diff0, diff1;
  logic                 due0, due1, cond0, cond1, occ_full, slot_free, emit, emit_frc;
  logic [RW:0]          rel_inc;

  assign diff0    = newest - c_time[0];
  assign diff1    = newest - c_time[1];
  assign due0     = CW'(diff0) >= CW'(wait_reg);
  assign due1     = CW'(diff1) >= CW'(wait_reg);
  assign rel_inc  = {1'b0, rel} + (RW+1)'(1);
  assign cond0    = (occ != '0) && (rel < RW'(STORE_DEPTH)) && due0;
  assign cond1    = (occ > OW'(1)) && (rel_inc < (RW+1)'(STORE_DEPTH)) && due1;
  assign occ_full = (occ == OW'(STORE_DEPTH + 1));
  assign emit_frc = !cond0 && (rel == '0) && occ_full;
  assign slot_free = !out_valid || out_ready;
  assign emit     = (state == tes_pkg::ST_DRAIN) && (cond0 || emit_frc) && slot_free;

  assign in_ready  = (state == tes_pkg::ST_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign kept_next = kept + tes_pkg::CNT_BITS'(!c_drp[0]);

  always_comb begin
    state_next  = state;
    occ_next    = occ;
    rel_next    = rel;
    newest_next = newest;
    ctl         = '0;
    unique case (state)
      tes_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.insert  = 1'b1;
          occ_next    = occ + OW'(1);
          rel_next    = '0;
          newest_next = ((occ == '0) || (event_time >= newest)) ? event_time : newest;
          state_next  = tes_pkg::ST_DRAIN;
        end
      end
      tes_pkg::ST_DRAIN: begin
        if (cond0 || emit_frc) begin
          if (slot_free) begin
            ctl.shift = 1'b1;
            occ_next  = occ - OW'(1);
            if (cond0) begin
              rel_next = rel_inc[RW-1:0];
            end
            if (emit_frc || !cond1) begin
              state_next = tes_pkg::ST_IDLE;
            end
          end
        end else begin
          state_next = tes_pkg::ST_IDLE;
        end
      end
      default: state_next = tes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tes_pkg::ST_IDLE;
      occ       <= '0;
      rel       <= '0;
      kept      <= '0;
      wait_reg  <= tes_pkg::WAIT_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      rel       <= rel_next;
      out_valid <= emit || (out_valid && !out_ready);
      if (emit) begin
        kept <= kept_next;
      end
      if (cfg_valid) begin
        wait_reg <= max_wait;
      end
    end
  end

  always_ff @(posedge clk) begin
    newest <= newest_next;
    if (emit) begin
      release_time <= c_time[0];
      out_tag      <= c_tag[0];
      out_dropped  <= c_drp[0];
      forced_out   <= emit_frc;
      kept_total   <= kept_next;
      last_of_run  <= emit_frc || !cond1;
    end
  end

  a_occ_idle: assert property (@(posedge clk) disable iff (rst)
    (state == tes_pkg::ST_IDLE) |-> (occ <= OW'(STORE_DEPTH)))
    else $error("store over depth between items");

  a_forced_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && forced_out) |-> last_of_run)
    else $error("forced release not last of run");

  a_rel_cap: assert property (@(posedge clk) disable iff (rst)
    rel <= RW'(STORE_DEPTH))
    else $error("release count beyond depth");

  a_accept_drain: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == tes_pkg::ST_DRAIN && occ != '0))
    else $error("accepted item not in store");

endmodule

// ===== rtl/tes_cell.sv =====
module tes_cell #(
  parameter int TIME_BITS = 48
) (
  input  logic                         clk,
  input  tes_pkg::cell_ctl_t           ctl,
  input  logic                         occupied,
  input  logic [TIME_BITS-1:0]         new_time,
  input  logic [tes_pkg::TAG_BITS-1:0] new_tag,
  input  logic                         new_dropped,
  input  logic                         prev_gt,
  input  logic                         prev_le,
  input  logic [TIME_BITS-1:0]         prev_time,
  input  logic [tes_pkg::TAG_BITS-1:0] prev_tag,
  input  logic                         prev_dropped,
  input  logic [TIME_BITS-1:0]         next_time,
  input  logic [tes_pkg::TAG_BITS-1:0] next_tag,
  input  logic                         next_dropped,
  output logic                         gt,
  output logic                         le,
  output logic [TIME_BITS-1:0]         cur_time,
  output logic [tes_pkg::TAG_BITS-1:0] cur_tag,
  output logic                         cur_dropped
);

  // equal times count as "le", so a new event lands after its equals
  assign gt = occupied && (cur_time > new_time);
  assign le = occupied && !gt;

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (prev_gt) begin
        cur_time    <= prev_time;
        cur_tag     <= prev_tag;
        cur_dropped <= prev_dropped;
      end else if (prev_le && !le) begin
        cur_time    <= new_time;
        cur_tag     <= new_tag;
        cur_dropped <= new_dropped;
      end
    end else if (ctl.shift) begin
      cur_time    <= next_time;
      cur_tag     <= next_tag;
      cur_dropped <= next_dropped;
    end
  end

endmodule
